### rtl/core/crt_two_moduli_signed_defines.svh
`ifndef CRT_TWO_MODULI_SIGNED_DEFINES_SVH
`define CRT_TWO_MODULI_SIGNED_DEFINES_SVH

// Clocked check, masked while reset is asserted
`define CRT2M_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds while reset is asserted
`define CRT2M_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/crt2m_pkg.sv
package crt2m_pkg;

  localparam int unsigned ResW      = 31;
  localparam int unsigned ModW      = 31;
  localparam int unsigned InvW      = 31;
  localparam int unsigned ConstW    = 32;
  localparam int unsigned DigW      = 32;
  localparam int unsigned ProdW     = 64;
  localparam int unsigned BigMW     = 2 * ModW;
  localparam int unsigned OutW      = 63;
  localparam int unsigned CfgW      = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned TdataInW  = 64;
  localparam int unsigned TdataOutW = 64;

  localparam int unsigned MulStages = 1;
  localparam int unsigned RedStages = 4;
  localparam int unsigned DigStages = MulStages + 2 * RedStages;
  localparam int unsigned CmbStages = 4;
  localparam int unsigned NumStages = DigStages + CmbStages;

  localparam logic [CfgIdxW-1:0] RegModA    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegModB    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMontA   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMontB   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegInvBInA = 3'd4;
  localparam logic [CfgIdxW-1:0] RegInvAInB = 3'd5;

  localparam logic [ModW-1:0] ModAReset = 31'd998244353;
  localparam logic [ModW-1:0] ModBReset = 31'd469762049;

endpackage

### rtl/core/crt2m_mont_reduce.sv
module crt2m_mont_reduce (
  input  logic                                  clk_i,
  input  logic [crt2m_pkg::RedStages-1:0]       en_i,
  input  logic [crt2m_pkg::ProdW-1:0]           p_i,
  input  logic [crt2m_pkg::ModW-1:0]            mod_i,
  input  logic [crt2m_pkg::ConstW-1:0]          mc_i,
  output logic [crt2m_pkg::DigW-1:0]            q_o
);

  logic [crt2m_pkg::ConstW-1:0] lo_prod;
  logic [crt2m_pkg::ConstW-1:0] t_d, t_q;
  logic [crt2m_pkg::ProdW-1:0]  p0_q, p1_q;
  logic [crt2m_pkg::ProdW-1:0]  tm_d, tm_q;
  logic [crt2m_pkg::ProdW-1:0]  sum;
  logic [crt2m_pkg::DigW-1:0]   r_d, r_q;
  logic [crt2m_pkg::DigW-1:0]   mod_ext;
  logic [crt2m_pkg::DigW-1:0]   q_d, q_q;

  assign lo_prod = p_i[crt2m_pkg::ConstW-1:0] * mc_i;
  assign t_d     = '0 - lo_prod;
  assign tm_d    = crt2m_pkg::ProdW'(t_q) * crt2m_pkg::ProdW'(mod_i);
  assign sum     = p1_q + tm_q;
  assign r_d     = sum[crt2m_pkg::ProdW-1 -: crt2m_pkg::DigW];
  assign mod_ext = crt2m_pkg::DigW'(mod_i);
  assign q_d     = (r_q >= mod_ext) ? r_q - mod_ext : r_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p0_q <= p_i;
      t_q  <= t_d;
    end
    if (en_i[1]) begin
      p1_q <= p0_q;
      tm_q <= tm_d;
    end
    if (en_i[2]) begin
      r_q <= r_d;
    end
    if (en_i[3]) begin
      q_q <= q_d;
    end
  end

  assign q_o = q_q;

endmodule

### rtl/core/crt2m_digit.sv
module crt2m_digit (
  input  logic                              clk_i,
  input  logic [crt2m_pkg::DigStages-1:0]   en_i,
  input  logic [crt2m_pkg::ResW-1:0]        res_i,
  input  logic [crt2m_pkg::InvW-1:0]        inv_i,
  input  logic [crt2m_pkg::ModW-1:0]        mod_i,
  input  logic [crt2m_pkg::ConstW-1:0]      mc_i,
  output logic [crt2m_pkg::DigW-1:0]        q_o
);

  logic [crt2m_pkg::ProdW-1:0] prod_d, prod_q;
  logic [crt2m_pkg::DigW-1:0]  v;

  assign prod_d = crt2m_pkg::ProdW'(res_i) * crt2m_pkg::ProdW'(inv_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
  end

  crt2m_mont_reduce u_red_mul (
    .clk_i (clk_i),
    .en_i  (en_i[crt2m_pkg::MulStages +: crt2m_pkg::RedStages]),
    .p_i   (prod_q),
    .mod_i (mod_i),
    .mc_i  (mc_i),
    .q_o   (v)
  );

  crt2m_mont_reduce u_red_out (
    .clk_i (clk_i),
    .en_i  (en_i[crt2m_pkg::MulStages + crt2m_pkg::RedStages +: crt2m_pkg::RedStages]),
    .p_i   (crt2m_pkg::ProdW'(v)),
    .mod_i (mod_i),
    .mc_i  (mc_i),
    .q_o   (q_o)
  );

endmodule

### rtl/core/crt2m_combine.sv
module crt2m_combine (
  input  logic                              clk_i,
  input  logic [crt2m_pkg::CmbStages-1:0]   en_i,
  input  logic [crt2m_pkg::DigW-1:0]        qa_i,
  input  logic [crt2m_pkg::DigW-1:0]        qb_i,
  input  logic [crt2m_pkg::ModW-1:0]        mod_a_i,
  input  logic [crt2m_pkg::ModW-1:0]        mod_b_i,
  output logic [crt2m_pkg::OutW-1:0]        combined_o
);

  logic [crt2m_pkg::BigMW-1:0] big_m_q;
  logic [crt2m_pkg::ProdW-1:0] big_m;
  logic [crt2m_pkg::ProdW-1:0] half;
  logic [crt2m_pkg::ProdW-1:0] pa_d, pa_q, pb_d, pb_q;
  logic [crt2m_pkg::ProdW-1:0] x_d, x_q;
  logic [crt2m_pkg::ProdW-1:0] x1_d, x1_q;
  logic                        sub2_d, sub2_q;
  logic [crt2m_pkg::ProdW-1:0] xo_d, xo_q;
  logic                        above;

  // Product modulus follows the configuration registers
  always_ff @(posedge clk_i) begin
    big_m_q <= crt2m_pkg::BigMW'(mod_a_i) * crt2m_pkg::BigMW'(mod_b_i);
  end

  assign big_m = crt2m_pkg::ProdW'(big_m_q);
  assign half  = big_m >> 1;

  assign pa_d   = crt2m_pkg::ProdW'(qa_i) * crt2m_pkg::ProdW'(mod_b_i);
  assign pb_d   = crt2m_pkg::ProdW'(qb_i) * crt2m_pkg::ProdW'(mod_a_i);
  assign x_d    = pa_q + pb_q;
  assign above  = x_q > half;
  assign x1_d   = above ? x_q - big_m : x_q;
  assign sub2_d = above && (x_q >= big_m);
  assign xo_d   = (sub2_q && (x1_q > half)) ? x1_q - big_m : x1_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (en_i[1]) begin
      x_q <= x_d;
    end
    if (en_i[2]) begin
      x1_q   <= x1_d;
      sub2_q <= sub2_d;
    end
    if (en_i[3]) begin
      xo_q <= xo_d;
    end
  end

  assign combined_o = xo_q[crt2m_pkg::OutW-1:0];

endmodule

### rtl/core/crt_two_moduli_signed.sv
// Throughput: one beat per cycle while the sink is ready; each of the 13 stages holds
// one item and a stage takes a new item whenever it is empty or its successor moves,
// so bubbles collapse.
// Reset: asynchronous, active low; clears all stage valid bits and loads the
// configuration registers with their defaults. No clearing pass follows.
module crt_two_moduli_signed (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [crt2m_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [crt2m_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [crt2m_pkg::TdataInW-1:0]      s_axis_tdata,  // residue_a, residue_b, zero pad
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [crt2m_pkg::TdataOutW-1:0]     m_axis_tdata,  // combined, zero pad
  output logic                                m_axis_tlast
);

  localparam int unsigned NumStages = crt2m_pkg::NumStages;
  localparam int unsigned ResW      = crt2m_pkg::ResW;

  logic [crt2m_pkg::ModW-1:0]   mod_a_q, mod_b_q;
  logic [crt2m_pkg::ConstW-1:0] mc_a_q, mc_b_q;
  logic [crt2m_pkg::InvW-1:0]   inv_b_in_a_q, inv_a_in_b_q;

  logic [NumStages-1:0] vld_q;
  logic [NumStages-1:0] last_q;
  logic [NumStages-1:0] en;

  logic [crt2m_pkg::DigW-1:0] qa, qb;
  logic [crt2m_pkg::OutW-1:0] combined;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_a_q      <= crt2m_pkg::ModAReset;
      mod_b_q      <= crt2m_pkg::ModBReset;
      mc_a_q       <= '0;
      mc_b_q       <= '0;
      inv_b_in_a_q <= '0;
      inv_a_in_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        crt2m_pkg::RegModA:    mod_a_q      <= cfg_data_i[crt2m_pkg::ModW-1:0];
        crt2m_pkg::RegModB:    mod_b_q      <= cfg_data_i[crt2m_pkg::ModW-1:0];
        crt2m_pkg::RegMontA:   mc_a_q       <= cfg_data_i[crt2m_pkg::ConstW-1:0];
        crt2m_pkg::RegMontB:   mc_b_q       <= cfg_data_i[crt2m_pkg::ConstW-1:0];
        crt2m_pkg::RegInvBInA: inv_b_in_a_q <= cfg_data_i[crt2m_pkg::InvW-1:0];
        crt2m_pkg::RegInvAInB: inv_a_in_b_q <= cfg_data_i[crt2m_pkg::InvW-1:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      last_q[0] <= s_axis_tlast;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  crt2m_digit u_digit_a (
    .clk_i (clk_i),
    .en_i  (en[crt2m_pkg::DigStages-1:0]),
    .res_i (s_axis_tdata[ResW-1:0]),
    .inv_i (inv_b_in_a_q),
    .mod_i (mod_a_q),
    .mc_i  (mc_a_q),
    .q_o   (qa)
  );

  crt2m_digit u_digit_b (
    .clk_i (clk_i),
    .en_i  (en[crt2m_pkg::DigStages-1:0]),
    .res_i (s_axis_tdata[2*ResW-1:ResW]),
    .inv_i (inv_a_in_b_q),
    .mod_i (mod_b_q),
    .mc_i  (mc_b_q),
    .q_o   (qb)
  );

  crt2m_combine u_combine (
    .clk_i      (clk_i),
    .en_i       (en[NumStages-1:crt2m_pkg::DigStages]),
    .qa_i       (qa),
    .qb_i       (qb),
    .mod_a_i    (mod_a_q),
    .mod_b_i    (mod_b_q),
    .combined_o (combined)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NumStages-1];
  assign m_axis_tlast  = last_q[NumStages-1];
  assign m_axis_tdata  = crt2m_pkg::TdataOutW'(combined);

endmodule

### rtl/core/crt2m_checker.sv
`include "crt_two_moduli_signed_defines.svh"

module crt2m_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [crt2m_pkg::TdataOutW-1:0]  m_axis_tdata,
  input logic                             m_axis_tlast
);

  `CRT2M_ASSERT(a_out_valid_held,
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid,
    "output beat dropped while stalled")
  `CRT2M_ASSERT(a_out_beat_stable,
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast),
    "output beat changed while stalled")
  `CRT2M_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
    "input stalled with empty output stage")
  `CRT2M_ASSERT(a_ready_follows_sink, m_axis_tready |-> s_axis_tready,
    "input stalled while sink takes beats")
  `CRT2M_ASSERT_ALWAYS(a_no_beat_in_reset, !rst_ni |=> !m_axis_tvalid,
    "output valid during reset")

endmodule

bind crt_two_moduli_signed crt2m_checker u_crt2m_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
